// ===== rtl/core/dct_pkg.sv =====
// ----------------------------------------------------------------------------
// dct_pkg
// Shared types, codes and character helpers for the doc comment tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dct_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] tok_type_t;

  // token type codes
  localparam tok_type_t TT_END   = 2'd0;
  localparam tok_type_t TT_SYM   = 2'd1;
  localparam tok_type_t TT_IDENT = 2'd2;

  // scan phase codes (token mode)
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_IDENT   = 2'd1;
  localparam logic [1:0] PH_OPSYM   = 2'd2;
  localparam logic [1:0] PH_OPPAREN = 2'd3;

  // marker progress codes (search mode)
  localparam logic [1:0] MP_NONE  = 2'd0;
  localparam logic [1:0] MP_SLASH = 2'd1;
  localparam logic [1:0] MP_STAR  = 2'd2;

  // keyword matching
  localparam logic [3:0] KW_LEN     = 4'd8;
  localparam logic [3:0] KW_NOMATCH = 4'd15;

  // result queue sizing
  localparam int RQ_DEPTH = 4;
  localparam int MAX_RES  = 3;

  // characters
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_LF     = 8'h0a;
  localparam byte_t CH_VT     = 8'h0b;
  localparam byte_t CH_FF     = 8'h0c;
  localparam byte_t CH_CR     = 8'h0d;
  localparam byte_t CH_SLASH  = 8'h2f;
  localparam byte_t CH_STAR   = 8'h2a;
  localparam byte_t CH_COLON  = 8'h3a;
  localparam byte_t CH_LPAREN = 8'h28;
  localparam byte_t CH_RPAREN = 8'h29;
  localparam byte_t CH_AMP    = 8'h26;
  localparam byte_t CH_UNDER  = 8'h5f;
  localparam byte_t CH_TILDE  = 8'h7e;
  localparam byte_t CH_LOW_O  = 8'h6f;

  // one result item
  typedef struct packed {
    byte_t     char_out;
    logic      token_start;
    logic      token_last;
    tok_type_t token_type;
  } res_t;

  // marker search step
  typedef struct packed {
    logic [1:0] prog;
    logic       hit;
  } srch_t;

  function automatic logic is_alpha(input byte_t c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_cont(input byte_t c);
    return (c == CH_UNDER) || is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_opsym(input byte_t c);
    return (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2a) || (c == 8'h2f) ||
           (c == 8'h25) || (c == 8'h5e) || (c == 8'h26) || (c == 8'h7c) ||
           (c == 8'h7e) || (c == 8'h21) || (c == 8'h3d) || (c == 8'h3c) ||
           (c == 8'h3e) || (c == 8'h5b) || (c == 8'h5d);
  endfunction

  // letters of "operator"
  function automatic byte_t kw_char(input logic [2:0] idx);
    byte_t c;
    unique case (idx)
      3'd0: c = 8'h6f;
      3'd1: c = 8'h70;
      3'd2: c = 8'h65;
      3'd3: c = 8'h72;
      3'd4: c = 8'h61;
      3'd5: c = 8'h74;
      3'd6: c = 8'h6f;
      3'd7: c = 8'h72;
    endcase
    return c;
  endfunction

  function automatic res_t mk_res(input byte_t ch, input logic st, input logic last,
                                  input tok_type_t tt);
    res_t r;
    r.char_out    = ch;
    r.token_start = st;
    r.token_last  = last;
    r.token_type  = tt;
    return r;
  endfunction

  function automatic srch_t search_step(input logic [1:0] prog, input byte_t b);
    srch_t s;
    s.hit = 1'b0;
    unique case (prog)
      MP_SLASH: s.prog = (b == CH_STAR) ? MP_STAR : ((b == CH_SLASH) ? MP_SLASH : MP_NONE);
      MP_STAR: begin
        s.prog = MP_NONE;
        s.hit  = (b == CH_COLON);
      end
      default: s.prog = (b == CH_SLASH) ? MP_SLASH : MP_NONE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dct_in_if.sv =====
// ----------------------------------------------------------------------------
// dct_in_if
// Input byte channel of the doc comment tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dct_in_if;
  logic            valid;
  logic            ready;
  logic            kind;
  dct_pkg::byte_t  char_in;
  logic            at_end;

  modport source (output valid, output kind, output char_in, output at_end, input ready);
  modport sink   (input valid, input kind, input char_in, input at_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dct_out_if.sv =====
// ----------------------------------------------------------------------------
// dct_out_if
// Token byte result channel of the doc comment tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dct_out_if;
  logic                valid;
  logic                ready;
  dct_pkg::byte_t      char_out;
  logic                token_start;
  logic                token_last;
  dct_pkg::tok_type_t  token_type;

  modport source (output valid, output char_out, output token_start, output token_last,
                  output token_type, input ready);
  modport sink   (input valid, input char_out, input token_start, input token_last,
                  input token_type, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/doc_comment_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// doc_comment_tokenizer_top
// Byte-stream tokenizer for slash-star-colon doc comments.
// ----------------------------------------------------------------------------
// Takes one source byte per item on in_chan and emits token bytes on out_chan,
// each tagged with start/last flags and a type (end, symbol, identifier). In
// search mode bytes are dropped until the slash-star-colon marker, which comes
// out as a three-byte symbol token. In token mode one byte is held back as
// lookahead, so a token byte leaves one item after it arrives; an end-of-input
// item flushes the held byte and adds an end token. Each input item is resolved
// in the cycle it is accepted and its zero to three result items are written
// into a four-entry result queue that drains one item per cycle while out_chan
// is ready. Input is taken every cycle while at least three queue entries are
// free, so with a ready output the sustained rate is one input item per cycle
// when each produces at most one result; otherwise the rate is set by the
// single output port of the result queue.
`timescale 1ns / 1ps
`default_nettype none

module doc_comment_tokenizer_top (
  input  wire logic clk,
  input  wire logic rst_n,
  dct_in_if.sink    in_chan,
  dct_out_if.source out_chan
);
  import dct_pkg::*;

  localparam int RQ_AW = $clog2(RQ_DEPTH);
  localparam int RQ_CW = $clog2(RQ_DEPTH + 1);

  // tokenizer state
  byte_t      held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       alb_r, alb_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] kw_r, kw_nxt;
  logic [1:0] mp_r, mp_nxt;

  // result queue
  res_t             rq_mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [RQ_CW-1:0] cnt_r;

  logic       in_acc, out_pop;
  res_t       step_res [MAX_RES];
  logic [1:0] step_n;

  // lookahead predicates, invalid on an end item
  logic pk_ok, p_cont, p_opsym, p_lparen, p_rparen, p_slash, p_star, p_amp, p_colon;

  // resolve results for the held byte
  res_t       rv_res0, rv_res1;
  logic [1:0] rv_n;
  logic [1:0] rv_phase;
  logic [3:0] rv_kw, kw_up;
  logic       rv_alb, rv_took;

  srch_t s_held, s_cur;

  assign in_chan.ready = (cnt_r <= RQ_CW'(RQ_DEPTH - MAX_RES));
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_pop       = out_chan.valid && out_chan.ready;

  assign pk_ok    = !in_chan.at_end;
  assign p_cont   = pk_ok && is_cont(in_chan.char_in);
  assign p_opsym  = pk_ok && is_opsym(in_chan.char_in);
  assign p_lparen = pk_ok && (in_chan.char_in == CH_LPAREN);
  assign p_rparen = pk_ok && (in_chan.char_in == CH_RPAREN);
  assign p_slash  = pk_ok && (in_chan.char_in == CH_SLASH);
  assign p_star   = pk_ok && (in_chan.char_in == CH_STAR);
  assign p_amp    = pk_ok && (in_chan.char_in == CH_AMP);
  assign p_colon  = pk_ok && (in_chan.char_in == CH_COLON);

  // keyword progress for a held identifier byte
  assign kw_up = ((kw_r < KW_LEN) && (held_byte_r == kw_char(kw_r[2:0]))) ?
                 (kw_r + 4'd1) : KW_NOMATCH;

  // resolve the held byte against the lookahead
  always_comb begin
    rv_n     = 2'd0;
    rv_res0  = '0;
    rv_res1  = '0;
    rv_phase = phase_r;
    rv_kw    = kw_r;
    rv_alb   = alb_r;
    rv_took  = 1'b0;
    unique case (phase_r)
      PH_IDENT: begin
        rv_kw = kw_up;
        rv_n  = 2'd1;
        if (p_cont) begin
          rv_res0 = mk_res(held_byte_r, 1'b0, 1'b0, TT_IDENT);
        end else if (kw_up == KW_LEN && p_lparen) begin
          rv_res0  = mk_res(held_byte_r, 1'b0, 1'b0, TT_IDENT);
          rv_phase = PH_OPPAREN;
        end else if (kw_up == KW_LEN && p_opsym) begin
          rv_res0  = mk_res(held_byte_r, 1'b0, 1'b0, TT_IDENT);
          rv_phase = PH_OPSYM;
        end else begin
          rv_res0  = mk_res(held_byte_r, 1'b0, 1'b1, TT_IDENT);
          rv_phase = PH_IDLE;
        end
      end
      PH_OPSYM: begin
        rv_n = 2'd1;
        if (p_opsym) begin
          rv_res0 = mk_res(held_byte_r, 1'b0, 1'b0, TT_IDENT);
        end else begin
          rv_res0  = mk_res(held_byte_r, 1'b0, 1'b1, TT_IDENT);
          rv_phase = PH_IDLE;
        end
      end
      PH_OPPAREN: begin
        rv_n = 2'd1;
        if (p_cont || p_star || p_amp) begin
          rv_res0 = mk_res(held_byte_r, 1'b0, 1'b0, TT_IDENT);
        end else if (p_rparen) begin
          rv_n     = 2'd2;
          rv_res0  = mk_res(held_byte_r, 1'b0, 1'b0, TT_IDENT);
          rv_res1  = mk_res(in_chan.char_in, 1'b0, 1'b1, TT_IDENT);
          rv_took  = 1'b1;
          rv_phase = PH_IDLE;
        end else begin
          rv_res0  = mk_res(held_byte_r, 1'b0, 1'b1, TT_IDENT);
          rv_phase = PH_IDLE;
        end
      end
      PH_IDLE: begin
        // blanks, line breaks, leading slashes and leading stars not followed by a slash are dropped
        priority if (held_byte_r == CH_SPACE || held_byte_r == CH_TAB ||
                     held_byte_r == CH_FF || held_byte_r == CH_VT) begin
          rv_n = 2'd0;
        end else if (held_byte_r == CH_LF || held_byte_r == CH_CR) begin
          rv_alb = 1'b1;
        end else if (held_byte_r == CH_STAR && alb_r && !p_slash) begin
          rv_n = 2'd0;
        end else if (held_byte_r == CH_SLASH && alb_r) begin
          rv_n = 2'd0;
        end else begin
          rv_alb = 1'b0;
          rv_n   = 2'd1;
          if (held_byte_r == CH_UNDER || held_byte_r == CH_TILDE || is_alpha(held_byte_r))
          begin
            rv_kw = (held_byte_r == CH_LOW_O) ? 4'd1 : KW_NOMATCH;
            if (p_cont) begin
              rv_res0  = mk_res(held_byte_r, 1'b1, 1'b0, TT_IDENT);
              rv_phase = PH_IDENT;
            end else begin
              rv_res0 = mk_res(held_byte_r, 1'b1, 1'b1, TT_IDENT);
            end
          end else if ((held_byte_r == CH_STAR && p_slash) ||
                       (held_byte_r == CH_COLON && p_colon) ||
                       (held_byte_r == CH_LPAREN && p_rparen)) begin
            rv_n    = 2'd2;
            rv_res0 = mk_res(held_byte_r, 1'b1, 1'b0, TT_SYM);
            rv_res1 = mk_res(in_chan.char_in, 1'b0, 1'b1, TT_SYM);
            rv_took = 1'b1;
          end else begin
            rv_res0 = mk_res(held_byte_r, 1'b1, 1'b1, TT_SYM);
          end
        end
      end
    endcase
  end

  // marker search over the held byte, then the new byte
  assign s_held = search_step(mp_r, held_byte_r);
  assign s_cur  = search_step((held_valid_r ? s_held.prog : mp_r), in_chan.char_in);

  // next state and result items for an accepted item
  always_comb begin
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    alb_nxt        = alb_r;
    phase_nxt      = phase_r;
    kw_nxt         = kw_r;
    mp_nxt         = mp_r;
    step_n         = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      step_res[i] = '0;
    end
    if (in_acc) begin
      if (!in_chan.kind) begin
        // search mode
        alb_nxt   = 1'b0;
        phase_nxt = PH_IDLE;
        kw_nxt    = 4'd0;
        if (in_chan.at_end) begin
          held_valid_nxt = 1'b0;
          mp_nxt         = MP_NONE;
          step_n         = 2'd1;
          step_res[0]    = mk_res(8'd0, 1'b1, 1'b1, TT_END);
        end else if (held_valid_r && s_held.hit) begin
          step_n         = 2'd3;
          step_res[0]    = mk_res(CH_SLASH, 1'b1, 1'b0, TT_SYM);
          step_res[1]    = mk_res(CH_STAR, 1'b0, 1'b0, TT_SYM);
          step_res[2]    = mk_res(CH_COLON, 1'b0, 1'b1, TT_SYM);
          held_byte_nxt  = in_chan.char_in;
          held_valid_nxt = 1'b1;
          mp_nxt         = s_held.prog;
        end else begin
          held_valid_nxt = 1'b0;
          mp_nxt         = s_cur.prog;
          if (s_cur.hit) begin
            step_n      = 2'd3;
            step_res[0] = mk_res(CH_SLASH, 1'b1, 1'b0, TT_SYM);
            step_res[1] = mk_res(CH_STAR, 1'b0, 1'b0, TT_SYM);
            step_res[2] = mk_res(CH_COLON, 1'b0, 1'b1, TT_SYM);
          end
        end
      end else begin
        // token mode
        mp_nxt = MP_NONE;
        if (in_chan.at_end) begin
          held_valid_nxt = 1'b0;
          phase_nxt      = PH_IDLE;
          alb_nxt        = 1'b0;
          kw_nxt         = 4'd0;
          if (held_valid_r && rv_n != 2'd0) begin
            step_n      = 2'd2;
            step_res[0] = rv_res0;
            step_res[1] = mk_res(8'd0, 1'b1, 1'b1, TT_END);
          end else begin
            step_n      = 2'd1;
            step_res[0] = mk_res(8'd0, 1'b1, 1'b1, TT_END);
          end
        end else if (!held_valid_r) begin
          held_byte_nxt  = in_chan.char_in;
          held_valid_nxt = 1'b1;
        end else begin
          step_n      = rv_n;
          step_res[0] = rv_res0;
          step_res[1] = rv_res1;
          phase_nxt   = rv_phase;
          kw_nxt      = rv_kw;
          alb_nxt     = rv_alb;
          if (rv_took) begin
            held_valid_nxt = 1'b0;
          end else begin
            held_byte_nxt  = in_chan.char_in;
            held_valid_nxt = 1'b1;
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      alb_r        <= 1'b0;
      phase_r      <= PH_IDLE;
      kw_r         <= 4'd0;
      mp_r         <= MP_NONE;
    end else begin
      held_valid_r <= held_valid_nxt;
      alb_r        <= alb_nxt;
      phase_r      <= phase_nxt;
      kw_r         <= kw_nxt;
      mp_r         <= mp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
  end

  // result queue storage, pointers wrap at the power-of-two depth
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < step_n) begin
        rq_mem[wr_ptr_r + RQ_AW'(i)] <= step_res[i];
      end
    end
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + RQ_AW'(step_n);
      rd_ptr_r <= rd_ptr_r + RQ_AW'(out_pop);
      cnt_r    <= cnt_r + RQ_CW'(step_n) - RQ_CW'(out_pop);
    end
  end

  assign out_chan.valid       = (cnt_r != '0);
  assign out_chan.char_out    = rq_mem[rd_ptr_r].char_out;
  assign out_chan.token_start = rq_mem[rd_ptr_r].token_start;
  assign out_chan.token_last  = rq_mem[rd_ptr_r].token_last;
  assign out_chan.token_type  = rq_mem[rd_ptr_r].token_type;

  // queue never holds more than its depth
  a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overflow");

  // an end token is a single closed item
  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.token_type == TT_END) |->
      (out_chan.token_start && out_chan.token_last && out_chan.char_out == 8'd0))
    else $error("malformed end token");

  // end of input leaves no lookahead and no open token
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.at_end) |=> (!held_valid_r && phase_r == PH_IDLE && mp_r == MP_NONE))
    else $error("state not cleared after end of input");

  // search mode keeps token state idle
  a_search_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_chan.kind) |=> (phase_r == PH_IDLE && kw_r == 4'd0 && !alb_r))
    else $error("token state active in search mode");

endmodule

`default_nettype wire
